// ----- rtl/core/serial_console_line_editor_macros.svh -----
// assertion macros for the serial console line editor
`ifndef SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH
`define SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

// next-cycle implication, checked outside reset
`define SCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// ----- rtl/core/sce_pkg.sv -----
// shared types, constants and codes of the serial console line editor
package sce_pkg;

    localparam int LINE_BUFFER_SIZE = 64;
    localparam int LINE_CAP         = LINE_BUFFER_SIZE - 1;
    localparam int CNT_W            = $clog2(LINE_BUFFER_SIZE);
    localparam int ADDR_W           = $clog2((LINE_CAP > 1) ? LINE_CAP : 2);

    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int ERASE_W = 6;
    localparam int KIND_W  = 3;

    localparam logic [BYTE_W-1:0] BYTE_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_DEL      = 8'h7F;
    localparam logic [BYTE_W-1:0] LAST_CONTROL  = 8'h1F;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO      = 3'd0,
        KIND_RUB_ONE   = 3'd1,
        KIND_RUB_COUNT = 3'd2,
        KIND_LINE_CHAR = 3'd3,
        KIND_EMPTY     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAR_W-1:0]   char_value;
        logic [ERASE_W-1:0]  erase_count;
        logic                last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ----- rtl/core/sce_byte_if.sv -----
// received byte channel
interface sce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sce_result_if.sv -----
// editor result channel
interface sce_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [6:0] char_value;
    logic [5:0] erase_count;
    logic       last;

    modport source (output valid, output kind, output char_value, output erase_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_value, input erase_count,
                    input last, output ready);
endinterface

// ----- rtl/core/serial_console_line_editor.sv -----
// serial console line editor top level
//
// takes received serial bytes one transaction at a time on rx and gives editor results on
// result. a byte is first caught in a one-entry holding register, so rx keeps taking a byte
// while a result still sits in the output register; the byte is decoded on the cycle after
// it is taken, provided the output register is free or being emptied. printable bytes
// (0x20 to 0x7e) are written to the line store and echoed while fewer than 63 characters
// are held; backspace or del gives one rub-out result, esc gives one rub-out-count result
// carrying the stored count, and both do nothing on an empty line. cr, or an lf that does
// not follow a cr, ends the line: an empty line gives one empty-line result with last set,
// otherwise the stored characters come out in order as line-char results, the final one
// marked last, and the line is emptied. an lf after a cr only clears the cr mark, and all
// other bytes are dropped. timing: rx is held off while the holding register is full, and
// a byte that gives at most one result leaves it on its decode cycle. a line end keeps the
// decoder busy after its own decode cycle with a read state and a send state per stored
// character, set by the registered read of the line store, and the send state waits for
// the output register to be free; bytes arriving meanwhile wait in the holding register.
// the line store has no reset and needs no clearing pass, since only entries below the
// count are ever read and each of those has been written
module serial_console_line_editor (
    input  logic          clk,
    input  logic          rst_n,
    sce_byte_if.sink      rx,
    sce_result_if.source  result
);
    import sce_pkg::*;

    // request from the sequencer to the line store
    ram_req_t          ram_req;
    // registered read data back from the line store
    logic [CHAR_W-1:0] ram_rdata;

    // decode, count, cr mark and line readout
    sce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .result    (result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // character store for the line being edited
    sce_line_ram u_line_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );
endmodule

// ----- rtl/core/sce_line_ram.sv -----
// line store: one write port, one read port, registered read data
module sce_line_ram (
    input  logic                       clk,
    input  sce_pkg::ram_req_t          req,
    output logic [sce_pkg::CHAR_W-1:0] rdata
);
    import sce_pkg::*;

    logic [CHAR_W-1:0] mem [LINE_CAP];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end
endmodule

// ----- rtl/core/sce_ctrl.sv -----
// byte decode, line counters and line readout sequencer
module sce_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    sce_byte_if.sink                   rx,
    sce_result_if.source               result,
    output sce_pkg::ram_req_t          ram_req,
    input  logic [sce_pkg::CHAR_W-1:0] ram_rdata
);
    import sce_pkg::*;

    state_t              state_reg, state_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]   pend_byte_reg, pend_byte_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                cr_seen_reg, cr_seen_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;

    logic                out_free;
    logic                is_rub;
    logic                is_print;
    logic                is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            cr_seen_reg    <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            cr_seen_reg    <= cr_seen_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        out_reg       <= out_next;
    end

    assign rx.ready           = !pend_valid_reg;
    assign result.valid       = out_valid_reg;
    assign result.kind        = out_reg.kind;
    assign result.char_value  = out_reg.char_value;
    assign result.erase_count = out_reg.erase_count;
    assign result.last        = out_reg.last;

    assign out_free = !out_valid_reg || result.ready;
    assign is_rub   = (pend_byte_reg == BYTE_BS) || (pend_byte_reg == BYTE_DEL);
    assign is_print = (pend_byte_reg > LAST_CONTROL) && (pend_byte_reg < BYTE_DEL);
    assign is_last  = (CNT_W'(idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        count_next      = count_reg;
        cr_seen_next    = cr_seen_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[ADDR_W-1:0];
        ram_req.wdata = pend_byte_reg[CHAR_W-1:0];
        ram_req.re    = 1'b0;
        ram_req.raddr = idx_reg[ADDR_W-1:0];

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rx.valid && !pend_valid_reg)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = rx.rx_byte;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pend_valid_reg && out_free)
                begin
                    pend_valid_next      = 1'b0;
                    out_next.kind        = KIND_ECHO;
                    out_next.char_value  = '0;
                    out_next.erase_count = '0;
                    out_next.last        = 1'b0;
                    if (is_rub)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next     = count_reg - CNT_W'(1);
                            out_next.kind  = KIND_RUB_ONE;
                            out_valid_next = 1'b1;
                        end
                    end
                    else if (pend_byte_reg == BYTE_ESC)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next           = '0;
                            out_next.kind        = KIND_RUB_COUNT;
                            out_next.erase_count = ERASE_W'(count_reg);
                            out_valid_next       = 1'b1;
                        end
                    end
                    else if ((pend_byte_reg == BYTE_LF) && cr_seen_reg)
                    begin
                        cr_seen_next = 1'b0;
                    end
                    else if ((pend_byte_reg == BYTE_CR) || (pend_byte_reg == BYTE_LF))
                    begin
                        if (pend_byte_reg == BYTE_CR)
                        begin
                            cr_seen_next = 1'b1;
                        end
                        if (count_reg == '0)
                        begin
                            out_next.kind  = KIND_EMPTY;
                            out_next.last  = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else if (is_print && (count_reg < CNT_W'(LINE_CAP)))
                    begin
                        ram_req.we          = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                        out_next.char_value = pend_byte_reg[CHAR_W-1:0];
                        out_valid_next      = 1'b1;
                    end
                end
            end

            ST_READ:
            begin
                ram_req.re = 1'b1;
                state_next = ST_SEND;
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = KIND_LINE_CHAR;
                    out_next.char_value  = ram_rdata;
                    out_next.erase_count = '0;
                    out_next.last        = is_last;
                    if (is_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/core/sce_checker.sv -----
// port-level checks of the serial console line editor, bound to the top level
`include "serial_console_line_editor_macros.svh"

module sce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [6:0] char_value,
    input logic [5:0] erase_count,
    input logic       last
);
    import sce_pkg::*;

    // a stalled result holds its value
    `SCE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable({kind, char_value, erase_count, last}))

    // only a line run end or an empty line carries last
    `SCE_ASSERT_NOW(a_last_kind, out_valid && last, (kind == KIND_LINE_CHAR) || (kind == KIND_EMPTY))

    // a character travels only with echo and line char
    `SCE_ASSERT_NOW(a_char_zero, out_valid && (kind != KIND_ECHO) && (kind != KIND_LINE_CHAR), char_value == '0)

    // a clear never reports an empty line
    `SCE_ASSERT_NOW(a_erase_nonzero, out_valid && (kind == KIND_RUB_COUNT), erase_count != '0)
endmodule

bind serial_console_line_editor sce_checker u_sce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .kind        (result.kind),
    .char_value  (result.char_value),
    .erase_count (result.erase_count),
    .last        (result.last)
);

// ----- bench/tb_serial_console_line_editor.sv -----
// testbench for the serial console line editor: scoreboard, stimulus and result checks
module tb_serial_console_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    import sce_pkg::*;

    // run limits, in clock cycles
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 200;    // room for a full line end to read out
    localparam int TOTAL_BYTES  = 350;    // bytes offered over the whole run

    // keeps its own copy of the line and the cr mark, and the results still owed
    class line_editor_sb;
        bit [CHAR_W-1:0] held_chars [LINE_CAP];
        int unsigned     held_count;
        bit              after_cr;
        res_t            pending_results[$];
        int unsigned     errors;
        int unsigned     checked;
        int unsigned     lines_ended;
        int unsigned     full_drops;

        function new();
            held_count  = 0;
            after_cr    = 1'b0;
            errors      = 0;
            checked     = 0;
            lines_ended = 0;
            full_drops  = 0;
        endfunction

        function void owe(kind_t k, bit [CHAR_W-1:0] ch, bit [ERASE_W-1:0] cnt, bit lst);
            res_t r;
            r.kind        = k;
            r.char_value  = ch;
            r.erase_count = cnt;
            r.last        = lst;
            pending_results.push_back(r);
        endfunction

        // works out what one accepted byte should give; returns 1 if the byte did anything
        function bit predict_byte(bit [BYTE_W-1:0] b);
            if (b == BYTE_BS || b == BYTE_DEL)
            begin
                if (held_count == 0)
                    return 1'b0;
                held_count--;
                owe(KIND_RUB_ONE, '0, '0, 1'b0);
                return 1'b1;
            end
            if (b == BYTE_ESC)
            begin
                if (held_count == 0)
                    return 1'b0;
                owe(KIND_RUB_COUNT, '0, held_count[ERASE_W-1:0], 1'b0);
                held_count = 0;
                return 1'b1;
            end
            if (b == BYTE_LF && after_cr)
            begin
                after_cr = 1'b0;
                return 1'b1;
            end
            if (b == BYTE_CR || b == BYTE_LF)
            begin
                if (b == BYTE_CR)
                    after_cr = 1'b1;
                if (held_count == 0)
                    owe(KIND_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < held_count; i++)
                        owe(KIND_LINE_CHAR, held_chars[i], '0, (i + 1 == held_count));
                held_count = 0;
                lines_ended++;
                return 1'b1;
            end
            if (b > LAST_CONTROL && b < BYTE_DEL)
            begin
                if (held_count >= LINE_CAP)
                begin
                    full_drops++;
                    return 1'b0;
                end
                held_chars[held_count] = b[CHAR_W-1:0];
                held_count++;
                owe(KIND_ECHO, b[CHAR_W-1:0], '0, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void field_ok(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(bit [KIND_W-1:0] k, bit [CHAR_W-1:0] ch,
                                   bit [ERASE_W-1:0] cnt, bit lst);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d char %0d count %0d last %0d",
                       k, ch, cnt, lst);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            field_ok("kind", want.kind, k);
            field_ok("char_value", want.char_value, ch);
            field_ok("erase_count", want.erase_count, cnt);
            field_ok("last", want.last, lst);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sce_byte_if   rx_if();
    sce_result_if res_if();

    serial_console_line_editor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    line_editor_sb sb;

    int unsigned bytes_sent;
    int unsigned bytes_acted;
    bit          no_idle;        // both sides keep going without gaps
    bit          stall_pending;  // asks the receiver for its long hold-off
    int          hold_left;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // every input known from time zero
    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        res_if.ready   = 1'b0;
        no_idle        = 1'b0;
        stall_pending  = 1'b0;
        hold_left      = 0;
        bytes_sent     = 0;
        bytes_acted    = 0;
        sb             = new();
    end

    // overall watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // receiver side: ready changes at the rising edge only; the long hold-off is
    // counted here so the sender keeps offering bytes until the block backs up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_pending)
            begin
                stall_pending = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (no_idle)
                res_if.ready <= 1'b1;
            else
                res_if.ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // result monitor: sampled at the falling edge, where valid and ready are settled
    // for the coming rising edge, so the transaction is counted without any race
    always @(negedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.kind, res_if.char_value, res_if.erase_count, res_if.last);
    end

    // offers one byte, with a random gap first, and returns just after the rising
    // edge that took it; valid stays high so a following byte goes out back to back
    task automatic send_byte(input bit [BYTE_W-1:0] b);
        bit taken;
        while (!no_idle && $urandom_range(0, 99) < 33)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (rx_if.ready)
            begin
                // this byte is taken at the next rising edge
                taken = 1'b1;
                bytes_sent++;
                if (sb.predict_byte(b))
                    bytes_acted++;
            end
            @(posedge clk);
        end
    endtask

    function automatic bit [BYTE_W-1:0] any_printable();
        return BYTE_W'($urandom_range(32'h20, 32'h7E));
    endfunction

    // a typed line with the odd edit, closed by one of the usual line endings
    task automatic send_line(input int len, input bit with_edits);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            send_byte(any_printable());
            if (with_edits && $urandom_range(0, 99) < 15)
            begin
                pick = $urandom_range(0, 2);
                send_byte(pick == 0 ? BYTE_BS : (pick == 1 ? BYTE_DEL : BYTE_ESC));
            end
        end
        case ($urandom_range(0, 3))
            0: send_byte(BYTE_CR);
            1: send_byte(BYTE_LF);
            2:
            begin
                send_byte(BYTE_CR);
                send_byte(BYTE_LF);
            end
            default:
            begin
                // a stray byte between cr and lf keeps the cr mark unless it is itself an lf
                send_byte(BYTE_CR);
                send_byte(BYTE_W'($urandom_range(0, 255)));
                send_byte(BYTE_LF);
            end
        endcase
    endtask

    // a run of control bytes and line ends, mostly hitting edge cases
    task automatic send_controls(input int n);
        bit [BYTE_W-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: b = BYTE_BS;
                1: b = BYTE_DEL;
                2: b = BYTE_ESC;
                3: b = BYTE_LF;
                4: b = BYTE_CR;
                default: b = BYTE_W'($urandom_range(0, 32'h1F));
            endcase
            send_byte(b);
        end
    endtask

    initial
    begin : stimulus
        bit [BYTE_W-1:0] directed [$];
        int              seq;
        int              pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        directed = '{
            BYTE_LF,                    // lf with no cr before it ends an empty line
            BYTE_CR,                    // empty line, sets the cr mark
            BYTE_LF,                    // pairs with the cr, no result
            BYTE_BS, BYTE_DEL, BYTE_ESC, // edits on an empty line give nothing
            8'h00, 8'h1F, 8'h80, 8'hFF, // dropped bytes
            8'h20, 8'h7E, 8'h41,        // printable limits and a plain letter
            BYTE_DEL, BYTE_BS,          // rub out one each
            BYTE_ESC,                   // rub out the remaining one by count
            8'h61, 8'h62, BYTE_CR,      // two-character line run
            8'h71,                      // other bytes keep the cr mark
            BYTE_LF,                    // clears the mark only
            BYTE_LF                     // now ends the line holding the one character
        };
        foreach (directed[i])
            send_byte(directed[i]);

        // long hold-off on the receiver while a line fills past its capacity,
        // then the full count is rubbed out and a full line is read out
        stall_pending = 1'b1;
        for (int i = 0; i < LINE_CAP + 7; i++)
            send_byte(any_printable());
        send_byte(BYTE_ESC);
        send_line(LINE_CAP, 1'b0);

        // random part, mostly well-formed lines with random content
        seq = 0;
        while (bytes_sent < TOTAL_BYTES)
        begin
            // a stretch with no gaps on either side
            no_idle = (seq >= 20 && seq < 35);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_line($urandom_range(0, 10), 1'b1);
            else if (pick < 70)
            begin
                for (int i = $urandom_range(LINE_CAP - 3, LINE_CAP + 3); i > 0; i--)
                    send_byte(any_printable());
                send_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_ESC);
            end
            else if (pick < 85)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            else
                send_controls($urandom_range(1, 6));
            seq++;
        end
        no_idle = 1'b0;
        rx_if.valid <= 1'b0;

        // wait for every owed result, then let the block settle
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes (%0d acted on), checked %0d results over %0d line ends",
                 bytes_sent, bytes_acted, sb.checked, sb.lines_ended);
        $display("printable bytes dropped on a full line: %0d", sb.full_drops);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
